// ===== design/aes_round_transform_macros.svh =====
// Assertion macros for the AES round transform block.
// Users must have i_clk and i_rst_n in scope.
`ifndef AES_ROUND_TRANSFORM_MACROS_SVH
`define AES_ROUND_TRANSFORM_MACROS_SVH

// Same-cycle implication; the consequent may carry its own delay.
`define ART_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aes_round_transform: assertion failed");

// Next-cycle implication.
`define ART_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aes_round_transform: assertion failed");

`endif

// ===== design/art_pkg.sv =====
// Shared types, constants and functions for the AES round transform.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package art_pkg;

    localparam int unsigned NUM_BYTES = 16;
    localparam logic [7:0] GF_POLY = 8'h1b;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
    } t_block_in;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_block_out;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] gf_times2(input logic [7:0] x);
        logic [7:0] y;
        y = {x[6:0], 1'b0};
        if (x[7]) begin
            y = y ^ GF_POLY;
        end
        return y;
    endfunction

    function automatic logic [7:0] gf_times3(input logic [7:0] x);
        return gf_times2(x) ^ x;
    endfunction

endpackage

`default_nettype wire

// ===== design/art_sub_lane.sv =====
// One substitution lane: adds a key byte to a state byte and looks it up in the S-box.
// Depends on art_pkg for the S-box table.
`timescale 1ns / 1ps
`default_nettype none

module art_sub_lane
    import art_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic [7:0] i_state,
    input  wire logic [7:0] i_key,
    output logic      [7:0] o_sub
);

    logic [7:0] r_sub;
    logic [7:0] n_sub;

    assign n_sub = SBOX[i_state ^ i_key];

    always_ff @(posedge i_clk) begin
        r_sub <= n_sub;
    end

    assign o_sub = r_sub;

endmodule

`default_nettype wire

// ===== design/art_mix_merge.sv =====
// Merging stage: row shift, column mixing and the second key addition over all lanes.
// Depends on art_pkg for the GF(2^8) helpers and the result type.
`timescale 1ns / 1ps
`default_nettype none

module art_mix_merge
    import art_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire logic [127:0] i_sub,
    input  wire logic [127:0] i_key,
    output logic              o_valid,
    output t_block_out        o_result
);

    logic         r_valid;
    logic         n_valid;
    logic [127:0] r_data;
    logic [127:0] n_data;

    always_comb begin
        logic [7:0] a [4];
        logic [7:0] m [4];
        n_data = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r] = i_sub[127 - 8 * (4 * ((c + r) % 4) + r) -: 8];
            end
            m[0] = gf_times2(a[0]) ^ gf_times3(a[1]) ^ a[2] ^ a[3];
            m[1] = a[0] ^ gf_times2(a[1]) ^ gf_times3(a[2]) ^ a[3];
            m[2] = a[0] ^ a[1] ^ gf_times2(a[2]) ^ gf_times3(a[3]);
            m[3] = gf_times3(a[0]) ^ a[1] ^ a[2] ^ gf_times2(a[3]);
            for (int r = 0; r < 4; r++) begin
                n_data[127 - 8 * (4 * c + r) -: 8] = m[r] ^ i_key[127 - 8 * (4 * c + r) -: 8];
            end
        end
    end

    assign n_valid = i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid  = r_valid;
    assign o_result = t_block_out'(r_data);

endmodule

`default_nettype wire

// ===== design/aes_round_transform.sv =====
// Top level of the AES round transform: key registers, sixteen substitution lanes
// and the merging stage. Depends on art_pkg, art_sub_lane, art_mix_merge and the macro header.
//
// Usage: a block is transferred in at a rising edge where start is high and busy is low.
// busy is high only during reset and until the first edge that samples reset released;
// otherwise a new block may be transferred in every cycle.
// A block transferred in is registered in the sixteen S-box lanes and then in the merging
// stage, and appears on o_result with o_valid high once the merging stage has registered it.
// Throughput is one block per cycle while busy is low: each of the two register stages of the
// datapath, the sixteen S-box lanes and the mixing stage, takes a new block every cycle.
// The round key is written through i_cfg_we, i_cfg_idx and i_cfg_data, by the user only
// while no block is in flight, which the block does not enforce; both halves reset to zero.
// Reset clears the pipeline valid flags, so no result appears after reset until a new
// transfer. The receiver cannot stall the block; each result is shown for one cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "aes_round_transform_macros.svh"

module aes_round_transform
    import art_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_block_in   i_block,
    output logic             o_valid,
    output t_block_out       o_result,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);

    logic [63:0]  r_key_high;
    logic [63:0]  r_key_low;
    logic         r_busy;
    logic         r_sub_valid;
    logic         n_sub_valid;
    logic [127:0] w_key;
    logic [127:0] w_state;
    logic [127:0] w_sub;

    assign w_key   = {r_key_high, r_key_low};
    assign w_state = {i_block.block_high, i_block.block_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign n_sub_valid = start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b1;
            r_sub_valid <= 1'b0;
        end else begin
            r_busy      <= 1'b0;
            r_sub_valid <= n_sub_valid;
        end
    end

    assign busy = r_busy;

    for (genvar k = 0; k < NUM_BYTES; k++) begin : g_lane
        art_sub_lane u_lane (
            .i_clk   (i_clk),
            .i_state (w_state[127 - 8 * k -: 8]),
            .i_key   (w_key[127 - 8 * k -: 8]),
            .o_sub   (w_sub[127 - 8 * k -: 8])
        );
    end

    art_mix_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_sub_valid),
        .i_sub    (w_sub),
        .i_key    (w_key),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    `ART_ASSERT_IMPL(a_accept_gives_result, start && !busy, ##2 o_valid)
    `ART_ASSERT_IMPL(a_result_has_source, o_valid, $past(start && !busy, 2))
    `ART_ASSERT_IMPL(a_busy_gives_no_result, busy, ##2 !o_valid)
    `ART_ASSERT_NEXT(a_lane_stage_follows, start && !busy, r_sub_valid)

endmodule

`default_nettype wire

// ===== sim/tb_aes_round_transform.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for aes_round_transform: one keyed AES round per block.
// Uses art_pkg for the port types and register indexes; the S-box and round are recomputed here.
module tb_aes_round_transform;
    import art_pkg::*;

    localparam logic [7:0] REDUCE_POLY  = 8'h1b;
    localparam logic [7:0] AFFINE_CONST = 8'h63;
    localparam int unsigned PIPE_LATENCY    = 4;
    localparam int unsigned RANDOM_PHASES   = 13;
    localparam int unsigned ITEMS_PER_PHASE = 150;
    localparam int unsigned CYCLE_LIMIT     = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_block_in   i_block = '0;
    logic        o_valid;
    t_block_out  o_result;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_KEY_HIGH;
    logic [63:0] i_cfg_data = '0;

    logic [7:0]  sbox_lut [256];
    logic [63:0] cur_key_high = '0;
    logic [63:0] cur_key_low = '0;
    t_block_out  expected_rounds [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    aes_round_transform dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_block    (i_block),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? REDUCE_POLY : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                p ^= x;
            end
            x = xtime(x);
        end
        return p;
    endfunction

    function automatic t_block_out predict_round(input t_block_in blk);
        logic [127:0] st;
        logic [127:0] key;
        logic [127:0] res;
        logic [7:0]   s [16];
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3;
        st = blk;
        key = {cur_key_high, cur_key_low};
        for (int k = 0; k < 16; k++) begin
            s[k] = sbox_lut[st[127 - 8 * k -: 8] ^ key[127 - 8 * k -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4 * c + r] = s[4 * ((c + r) % 4) + r];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4 * c];
            a1 = t[4 * c + 1];
            a2 = t[4 * c + 2];
            a3 = t[4 * c + 3];
            res[127 - 32 * c -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            res[119 - 32 * c -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            res[111 - 32 * c -: 8]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            res[103 - 32 * c -: 8]  = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return t_block_out'(res ^ key);
    endfunction

    function automatic logic [63:0] random_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: begin
                w = w & {$urandom, $urandom};
            end
            1: begin
                w = w | {$urandom, $urandom};
            end
            default: begin
            end
        endcase
        return w;
    endfunction

    function automatic void report_mismatch(input string what, input t_block_out want,
                                            input t_block_out got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] mismatch on %s: expected %h_%h, got %h_%h", $realtime, what,
                     want.result_high, want.result_low, got.result_high, got.result_low);
        end
    endfunction

    // Called just after a rising edge; returns just after the edge that takes the transfer.
    task automatic send_block(input t_block_in blk, input int unsigned gap);
        if (gap > 0) begin
            start <= 1'b0;
            i_block <= t_block_in'({random_word(), random_word()});
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_block <= blk;
        do @(posedge i_clk); while (busy !== 1'b0);
        expected_rounds.push_back(predict_round(blk));
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_rounds.size() != 0);
        repeat (PIPE_LATENCY) @(posedge i_clk);
    endtask

    task automatic set_round_key(input logic [63:0] key_high, input logic [63:0] key_low);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_KEY_HIGH;
        i_cfg_data <= key_high;
        @(posedge i_clk);
        i_cfg_idx <= CFG_KEY_LOW;
        i_cfg_data <= key_low;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_key_high = key_high;
        cur_key_low = key_low;
    endtask

    // The key is still at its reset value of zero here; blocks go in back to back.
    task automatic test_reset_key();
        send_block('0, 0);
        send_block('1, 0);
        send_block(t_block_in'({64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa}), 0);
        send_block(t_block_in'({64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f}), 0);
        send_block(t_block_in'({64'h0, 64'hffff_ffff_ffff_ffff}), 0);
        send_block(t_block_in'({64'hffff_ffff_ffff_ffff, 64'h0}), 0);
        send_block(t_block_in'({64'h8080_8080_8080_8080, 64'h7f7f_7f7f_7f7f_7f7f}), 0);
        wait_for_results();
    endtask

    task automatic test_key_extremes();
        set_round_key('1, '1);
        send_block('0, 0);
        send_block('1, 1);
        send_block(t_block_in'({64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210}), 0);
        wait_for_results();
        set_round_key('1, '0);
        send_block('0, 0);
        send_block('1, 0);
        wait_for_results();
        set_round_key('0, '1);
        send_block('0, 2);
        send_block('1, 0);
        wait_for_results();
        set_round_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f);
        send_block(t_block_in'({64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff}), 0);
        send_block(t_block_in'({64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f}), 0);
        wait_for_results();
    endtask

    // Every third phase runs without gaps so that transfers arrive on consecutive edges.
    task automatic test_random_rounds();
        logic [63:0] kh;
        logic [63:0] kl;
        int unsigned gap;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    kh = '0;
                    kl = '1;
                end
                1: begin
                    kh = '1;
                    kl = '1;
                end
                2: begin
                    kh = '0;
                    kl = '0;
                end
                default: begin
                    kh = random_word();
                    kl = random_word();
                end
            endcase
            set_round_key(kh, kl);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                gap = (phase % 3 == 1) ? 0 : $urandom_range(0, 8);
                send_block(t_block_in'({random_word(), random_word()}), gap);
            end
            wait_for_results();
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_block_out want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (expected_rounds.size() == 0) begin
                report_mismatch("unexpected transfer", '0, o_result);
            end else begin
                want = expected_rounds.pop_front();
                if (o_result.result_high !== want.result_high) begin
                    report_mismatch("result_high", want, o_result);
                end
                if (o_result.result_low !== want.result_low) begin
                    report_mismatch("result_low", want, o_result);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [7:0] inv;
        logic [7:0] b;
        // The S-box is the GF(2^8) inverse followed by the affine map.
        for (int x = 0; x < 256; x++) begin
            inv = 8'h01;
            repeat (254) inv = gf_mul(inv, 8'(x));
            b = (x == 0) ? 8'h00 : inv;
            sbox_lut[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                          ^ {b[3:0], b[7:4]} ^ AFFINE_CONST;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        test_reset_key();
        test_key_extremes();
        test_random_rounds();
        if (mismatch_count == 0 && expected_rounds.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== aes_round_transform.f =====
+incdir+design
design/art_pkg.sv
design/art_sub_lane.sv
design/art_mix_merge.sv
design/aes_round_transform.sv
sim/tb_aes_round_transform.sv
